// ===== rtl/page_run_allocator_top_macros.svh =====
// ---------------------------------------------------------------------------
// page_run_allocator_top_macros
// Assertion helpers used by the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef PAGE_RUN_ALLOCATOR_TOP_MACROS_SVH
`define PAGE_RUN_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define PRA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pra_pkg.sv =====
// ---------------------------------------------------------------------------
// pra_pkg
// Types and codes of the page run allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package pra_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_WIN_END,
        ST_MARK,
        ST_FREE_RD,
        ST_FREE_EV,
        ST_FREE_CLR,
        ST_DONE
    } t_state;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOFIT   = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
    localparam logic [1:0] STATUS_ZERO    = 2'd3;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_NEXT  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] CFG_STRATEGY  = 2'd0;
    localparam logic [1:0] CFG_HEAP_BASE = 2'd1;

    localparam logic [31:0] HEAP_BASE_RESET = 32'h8000_0000;

endpackage

`default_nettype wire

// ===== rtl/page_run_allocator_top.sv =====
// ---------------------------------------------------------------------------
// page_run_allocator_top
// Page run allocator with first, best, worst and next fit placement.
// ---------------------------------------------------------------------------
// After reset the block sweeps both page stores, one page a cycle, before it
// takes its first request. An allocate request walks the page map through one
// read port, reading and then evaluating each page scanned (next fit may take
// a second, shorter pass), then marks one page a cycle for the pages granted.
// A free request reads the run length stored for its first page, checks it,
// then clears the pages of that run in order. One request is in work at a
// time; the result sits in an output register until it is taken. PAGE_BYTES
// must be a power of two.
`default_nettype none

module page_run_allocator_top
    import pra_pkg::*;
#(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_request_bytes,
    input  wire logic [31:0] i_release_address,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_block_address,
    output logic [10:0]      o_block_page_count
);

    localparam int PW = $clog2(NUM_PAGES);
    localparam int CW = $clog2(NUM_PAGES + 1);
    localparam int SH = $clog2(PAGE_BYTES);
    localparam logic [31:0] OFS_MASK = 32'(PAGE_BYTES - 1);
    localparam logic [CW-1:0] N_PAGES = CW'(NUM_PAGES);
    localparam logic [PW-1:0] LAST_PAGE = PW'(NUM_PAGES - 1);

    t_state r_state, n_state;

    logic [1:0]    r_strategy;
    logic [31:0]   r_heap_base;
    logic [PW-1:0] r_clr;

    logic          r_op;
    logic [31:0]   r_bytes;
    logic [31:0]   r_rounded;
    logic [CW-1:0] r_need;
    logic [CW-1:0] r_p;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_old;
    logic [CW-1:0] r_nf_ptr;
    logic          r_phase2;
    logic [PW-1:0] r_run_start;
    logic [CW-1:0] r_run_len;
    logic [PW-1:0] r_pick;
    logic [CW-1:0] r_pick_len;
    logic          r_found;
    logic [CW-1:0] r_k;

    logic [1:0]    r_status;
    logic [31:0]   r_blk_addr;
    logic [CW-1:0] r_blk_cnt;

    // page stores
    logic          r_used_mem [NUM_PAGES];
    logic [CW-1:0] r_len_mem  [NUM_PAGES];
    logic          r_used_q;
    logic [CW-1:0] r_len_q;

    logic          used_we, used_wd, len_we;
    logic [PW-1:0] used_wa, len_wa;
    logic [CW-1:0] len_wd;

    // request decode
    logic [32:0]   bytes_up;
    logic [32:0]   need_full;
    logic [31:0]   diff;
    logic [31:0]   idx_full;
    logic          free_bad;

    // scan evaluation
    logic          pg_free, ended, fits, take, stop;
    logic [CW-1:0] s_len;
    logic [PW-1:0] s_start;
    logic [PW-1:0] k_page;

    assign bytes_up  = {1'b0, r_bytes} + 33'(PAGE_BYTES - 1);
    assign need_full = bytes_up >> SH;
    assign diff      = r_rounded - r_heap_base;
    assign idx_full  = diff >> SH;
    assign free_bad  = ((diff & OFS_MASK) != 32'd0) || (idx_full >= 32'(NUM_PAGES));

    assign pg_free = !r_used_q;
    assign s_len   = pg_free ? r_run_len + CW'(1) : r_run_len;
    assign s_start = (pg_free && r_run_len == '0) ? r_p[PW-1:0] : r_run_start;
    assign ended   = !pg_free || (r_p + CW'(1) == r_hi);
    assign fits    = ended && (s_len >= r_need);
    assign take    = fits && (!r_found
                     || (r_strategy == FIT_BEST  && s_len < r_pick_len)
                     || (r_strategy == FIT_WORST && s_len > r_pick_len));
    assign stop    = take && (r_strategy == FIT_FIRST || r_strategy == FIT_NEXT);
    assign k_page  = r_pick + r_k[PW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:    if (r_clr == LAST_PAGE) n_state = ST_IDLE;
            ST_IDLE:     if (i_in_valid) n_state = ST_SETUP;
            ST_SETUP: begin
                if (r_op == OP_FREE) begin
                    n_state = free_bad ? ST_DONE : ST_FREE_RD;
                end else if (r_bytes == 32'd0 || need_full > 33'(NUM_PAGES)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:  n_state = (r_p < r_hi) ? ST_SCAN_EV : ST_WIN_END;
            ST_SCAN_EV:  n_state = stop ? ST_WIN_END : ST_SCAN_RD;
            ST_WIN_END: begin
                if (r_found) begin
                    n_state = ST_MARK;
                end else if (r_strategy == FIT_NEXT && !r_phase2) begin
                    n_state = ST_SCAN_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MARK:     if (r_k + CW'(1) == r_need) n_state = ST_DONE;
            ST_FREE_RD:  n_state = ST_FREE_EV;
            ST_FREE_EV:  n_state = (r_len_q == '0) ? ST_DONE : ST_FREE_CLR;
            ST_FREE_CLR: if (r_k + CW'(1) == r_need) n_state = ST_DONE;
            ST_DONE:     if (i_out_ready) n_state = ST_IDLE;
            default:     n_state = ST_CLEAR;
        endcase
    end

    // outputs and store write ports
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        used_we     = 1'b0;
        used_wa     = k_page;
        used_wd     = 1'b0;
        len_we      = 1'b0;
        len_wa      = r_pick;
        len_wd      = '0;
        unique case (r_state)
            ST_CLEAR: begin
                used_we = 1'b1;
                used_wa = r_clr;
                len_we  = 1'b1;
                len_wa  = r_clr;
            end
            ST_IDLE:  o_in_ready = 1'b1;
            ST_MARK: begin
                used_we = 1'b1;
                used_wd = 1'b1;
                len_we  = (r_k == '0);
                len_wd  = r_need;
            end
            ST_FREE_CLR: begin
                used_we = 1'b1;
                len_we  = (r_k == '0);
            end
            ST_DONE:  o_out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (used_we) r_used_mem[used_wa] <= used_wd;
        if (len_we)  r_len_mem[len_wa] <= len_wd;
        r_used_q <= r_used_mem[r_p[PW-1:0]];
        r_len_q  <= r_len_mem[r_pick];
    end

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_strategy  <= FIT_FIRST;
            r_heap_base <= HEAP_BASE_RESET;
            r_clr       <= '0;
            r_nf_ptr    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_STRATEGY)  r_strategy  <= i_cfg_data[1:0];
                if (i_cfg_index == CFG_HEAP_BASE) r_heap_base <= i_cfg_data;
            end
            unique case (r_state)
                ST_CLEAR: r_clr <= r_clr + PW'(1);
                ST_IDLE: begin
                    r_op      <= i_operation;
                    r_bytes   <= i_request_bytes;
                    r_rounded <= i_release_address & ~OFS_MASK;
                end
                ST_SETUP: begin
                    r_blk_addr  <= '0;
                    r_blk_cnt   <= '0;
                    r_found     <= 1'b0;
                    r_run_len   <= '0;
                    r_run_start <= '0;
                    r_pick_len  <= '0;
                    r_phase2    <= 1'b0;
                    r_hi        <= N_PAGES;
                    r_old       <= r_nf_ptr;
                    r_p         <= (r_strategy == FIT_NEXT) ? r_nf_ptr : '0;
                    r_need      <= need_full[CW-1:0];
                    r_pick      <= idx_full[PW-1:0];
                    if (r_op == OP_FREE) begin
                        r_status <= free_bad ? STATUS_UNKNOWN : STATUS_OK;
                    end else if (r_bytes == 32'd0) begin
                        r_status <= STATUS_ZERO;
                    end else if (need_full > 33'(NUM_PAGES)) begin
                        r_status <= STATUS_NOFIT;
                        if (r_strategy == FIT_NEXT) r_nf_ptr <= '0;
                    end else begin
                        r_status <= STATUS_OK;
                    end
                end
                ST_SCAN_EV: begin
                    if (take) begin
                        r_pick     <= s_start;
                        r_pick_len <= s_len;
                        r_found    <= 1'b1;
                    end
                    r_run_len   <= ended ? '0 : s_len;
                    r_run_start <= s_start;
                    r_p         <= r_p + CW'(1);
                end
                ST_WIN_END: begin
                    r_k <= '0;
                    if (r_found) begin
                        if (r_strategy == FIT_NEXT) r_nf_ptr <= CW'(r_pick) + r_need;
                    end else if (r_strategy == FIT_NEXT && !r_phase2) begin
                        r_nf_ptr  <= '0;
                        r_phase2  <= 1'b1;
                        r_p       <= '0;
                        r_hi      <= r_old;
                        r_run_len <= '0;
                    end else begin
                        r_status <= STATUS_NOFIT;
                    end
                end
                ST_MARK: begin
                    r_k <= r_k + CW'(1);
                    if (r_k + CW'(1) == r_need) begin
                        r_blk_addr <= r_heap_base + (32'(r_pick) << SH);
                        r_blk_cnt  <= r_need;
                    end
                end
                ST_FREE_EV: begin
                    r_k    <= '0;
                    r_need <= r_len_q;
                    if (r_len_q == '0) r_status <= STATUS_UNKNOWN;
                end
                ST_FREE_CLR: begin
                    r_k <= r_k + CW'(1);
                    if (r_k + CW'(1) == r_need) begin
                        r_blk_addr <= r_rounded;
                        r_blk_cnt  <= r_need;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_status           = r_status;
    assign o_block_address    = r_blk_addr;
    assign o_block_page_count = 11'(r_blk_cnt);

`include "page_run_allocator_top_macros.svh"

    `PRA_ASSERT_SAME(a_ready_excl, o_in_ready, !o_out_valid, "ready while result pending")
    `PRA_ASSERT_NEXT(a_busy_after_req, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `PRA_ASSERT_SAME(a_err_zero, o_out_valid && o_status != STATUS_OK,
        o_block_address == 32'd0 && o_block_page_count == 11'd0, "error result not cleared")
    `PRA_ASSERT_SAME(a_ok_count, o_out_valid && o_status == STATUS_OK,
        r_blk_cnt != '0, "ok result without pages")
    `PRA_ASSERT_SAME(a_scan_window, r_state == ST_SCAN_EV, r_p < r_hi, "scan past window")

endmodule

`default_nettype wire
